// ===== design/assert_macros.svh =====
// Concurrent assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_DIS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_DIS(lbl, clk, rst, prop)

`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== design/ltrr_pkg.sv =====
package ltrr_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_FLUSH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STAT_DATA    = 2'd0,
    STAT_NO_LINE = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_t;

  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_NUL = 8'h00;

endpackage

// ===== design/ltrr_ram.sv =====
module ltrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/line_terminated_receive_ring_top.sv =====
// Line-terminated receive ring.
// Slave stream: one request per transfer. tuser selects the kind (received
// byte, read, flush); tdata carries the byte and the read length.
// Master stream: read results, one byte per transfer, tuser gives the status
// and tlast marks the final result of a read.
// A received byte or a flush produces nothing. A CR LF
// pair ends a line: the CR becomes zero, the LF is dropped and further bytes
// are dropped until a read.
// A read delivers one byte per cycle while the master side does not stall,
// from the ring RAM read port, up to MAX_RUN bytes; a read with no line
// ready, or with nothing to return, gives a single status result. A new
// request is taken once the previous read has issued all its RAM reads or sent its status result.
// Reset clears positions, the line flag and the output; ring contents are
// left as they are. When the master side stalls, the output register and the
// RAM read register hold and the read run pauses; the slave side stays
// blocked until the run finishes issuing.
module line_terminated_receive_ring_top #(
  parameter int RING_DEPTH = 512,
  parameter int MAX_RUN    = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_byte[7:0], read_length[14:8], zero
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // data_byte[7:0]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  output logic        m_axis_tlast
);

  `include "assert_macros.svh"

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int RUN_W = $clog2(MAX_RUN + 1);
  localparam int CMP_W = (PTR_W > 7) ? PTR_W : 7;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_SPAN = PTR_W'(RING_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_STAT} state_t;

  state_t               state;
  ltrr_pkg::status_t    stat_code;
  logic [PTR_W-1:0]     wp;
  logic [PTR_W-1:0]     rp;
  logic                 line_ready;
  logic [7:0]           prev_stored;
  logic [RUN_W-1:0]     remain;
  logic                 rd_valid;
  logic                 rd_last;
  logic [7:0]           rd_data;
  logic                 out_valid;
  logic [7:0]           out_data;
  ltrr_pkg::status_t    out_status;
  logic                 out_last;

  ltrr_pkg::req_t       req;
  logic [7:0]           rx_byte;
  logic [6:0]           read_length;
  logic                 accept;
  logic                 out_adv;
  logic                 rd_adv;
  logic                 issue;
  logic                 crlf;
  logic                 wr_en;
  logic [PTR_W-1:0]     wr_addr;
  logic [7:0]           wr_data;
  logic [PTR_W-1:0]     wp_back;
  logic [PTR_W-1:0]     wp_inc;
  logic [PTR_W-1:0]     rp_inc;
  logic [PTR_W-1:0]     count;
  logic [6:0]           want;
  logic [CMP_W-1:0]     want_e;
  logic [CMP_W-1:0]     count_e;
  logic [CMP_W-1:0]     n_wide;
  logic [RUN_W-1:0]     n;

  assign req         = ltrr_pkg::req_t'(s_axis_tuser);
  assign rx_byte     = s_axis_tdata[7:0];
  assign read_length = s_axis_tdata[14:8];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign out_adv = !out_valid || m_axis_tready;
  assign rd_adv  = !rd_valid || out_adv;
  assign issue   = (state == ST_RUN) && rd_adv;

  assign wp_back = (wp == '0) ? PTR_LAST : wp - 1'b1;
  assign wp_inc  = (wp == PTR_LAST) ? '0 : wp + 1'b1;
  assign rp_inc  = (rp == PTR_LAST) ? '0 : rp + 1'b1;

  assign crlf    = (rx_byte == ltrr_pkg::CHAR_LF) && (prev_stored == ltrr_pkg::CHAR_CR);
  assign wr_en   = accept && (req == ltrr_pkg::REQ_BYTE) && !line_ready;
  assign wr_addr = crlf ? wp_back : wp;
  assign wr_data = crlf ? ltrr_pkg::CHAR_NUL : rx_byte;

  assign count   = (wp >= rp) ? wp - rp : wp - rp + PTR_SPAN;
  assign want    = (read_length > 7'(MAX_RUN)) ? 7'(MAX_RUN) : read_length;
  assign want_e  = CMP_W'(want);
  assign count_e = CMP_W'(count);
  assign n_wide  = (want_e < count_e) ? want_e : count_e;
  assign n       = n_wide[RUN_W-1:0];

  ltrr_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_adv),
    .rd_addr(rp),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stat_code   <= ltrr_pkg::STAT_DATA;
      wp          <= '0;
      rp          <= '0;
      line_ready  <= 1'b0;
      prev_stored <= '0;
      remain      <= '0;
      rd_valid    <= 1'b0;
      rd_last     <= 1'b0;
      out_valid   <= 1'b0;
      out_data    <= '0;
      out_status  <= ltrr_pkg::STAT_DATA;
      out_last    <= 1'b0;
    end else begin
      // drain the RAM stage first, then a pending status
      if (out_adv) begin
        if (rd_valid) begin
          out_valid  <= 1'b1;
          out_data   <= rd_data;
          out_status <= ltrr_pkg::STAT_DATA;
          out_last   <= rd_last;
        end else if (state == ST_STAT) begin
          out_valid  <= 1'b1;
          out_data   <= ltrr_pkg::CHAR_NUL;
          out_status <= stat_code;
          out_last   <= 1'b1;
          state      <= ST_IDLE;
        end else begin
          out_valid <= 1'b0;
        end
      end

      if (rd_adv) begin
        rd_valid <= issue;
        rd_last  <= (remain == RUN_W'(1));
      end

      if (issue) begin
        rp     <= rp_inc;
        remain <= remain - 1'b1;
        if (remain == RUN_W'(1)) begin
          state <= ST_IDLE;
        end
      end

      if (accept) begin
        unique case (req)
          ltrr_pkg::REQ_BYTE: begin
            if (!line_ready) begin
              if (crlf) begin
                prev_stored <= ltrr_pkg::CHAR_NUL;
                line_ready  <= 1'b1;
              end else begin
                prev_stored <= rx_byte;
                wp          <= wp_inc;
              end
            end
          end
          ltrr_pkg::REQ_READ: begin
            if (!line_ready) begin
              state     <= ST_STAT;
              stat_code <= ltrr_pkg::STAT_NO_LINE;
            end else begin
              line_ready <= 1'b0;
              if (n == '0) begin
                state     <= ST_STAT;
                stat_code <= ltrr_pkg::STAT_EMPTY;
              end else begin
                state  <= ST_RUN;
                remain <= n;
              end
            end
          end
          ltrr_pkg::REQ_FLUSH: begin
            rp <= wp;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;
  assign m_axis_tlast  = out_last;

  `ASSERT_DIS(a_status_is_last, clk, rst,
    out_valid && (out_status != ltrr_pkg::STAT_DATA) |-> out_last && (out_data == '0))
  `ASSERT_DIS(a_rd_stage_holds, clk, rst,
    rd_valid && !out_adv |=> rd_valid && $stable(rd_data))
  `ASSERT_DIS(a_no_accept_in_run, clk, rst,
    (state == ST_RUN) |-> (remain != '0) && !wr_en)
  `ASSERT_DIS(a_ptr_in_range, clk, rst,
    (wp <= PTR_LAST) && (rp <= PTR_LAST))
  `ASSERT_ALWAYS(a_reset_clears_out, clk,
    rst |=> !m_axis_tvalid && s_axis_tready)

endmodule
